@@ sv/assert_macros.svh @@
// assertion macros shared by the trace record parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define TPR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define TPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tpr_pkg.sv @@
// shared types and constants of the trace record parser
package tpr_pkg;

   localparam int CHAR_W          = 7;
   localparam int DATA_W          = 64;
   localparam int SIZE_W          = 32;
   localparam int HEX_TERM_W      = 7;
   localparam int DEC_TERM_W      = 8;
   localparam int ADDR_WIDTH_DEF  = 64;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [CHAR_W-1:0] CH_TAB     = 7'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 7'h39;
   localparam logic [CHAR_W-1:0] CASE_MASK  = 7'h5F;
   // 'A' minus ten
   localparam logic [CHAR_W-1:0] HEX_ALPHA_BASE = 7'h37;

   typedef struct packed {
      logic                         at_end;
      logic                         is_ws;
      logic                         is_nl;
      logic [CHAR_W-1:0]            ch;
      logic signed [HEX_TERM_W-1:0] hex_term;
      logic signed [DEC_TERM_W-1:0] dec_term;
   } beat_type;

endpackage

@@ sv/tpr_front.sv @@
// front end: classifies each text byte into a decoded beat
module tpr_front (
   input  logic [tpr_pkg::CHAR_W-1:0] char_in,
   input  logic                       at_end,
   output tpr_pkg::beat_type          beat
);

   logic [tpr_pkg::DEC_TERM_W-1:0] wide_ch;
   logic [tpr_pkg::DEC_TERM_W-1:0] hex_wide;

   always_comb begin
      wide_ch = {1'b0, char_in};
      if (char_in <= tpr_pkg::CH_NINE) begin
         hex_wide = wide_ch - {1'b0, tpr_pkg::CH_ZERO};
      end else begin
         hex_wide = {1'b0, char_in & tpr_pkg::CASE_MASK} - {1'b0, tpr_pkg::HEX_ALPHA_BASE};
      end

      beat.at_end   = at_end;
      beat.is_ws    = (char_in == tpr_pkg::CH_SPACE) ||
                      ((char_in >= tpr_pkg::CH_TAB) && (char_in <= tpr_pkg::CH_CR));
      beat.is_nl    = (char_in == tpr_pkg::CH_NEWLINE);
      beat.ch       = char_in;
      beat.hex_term = hex_wide[tpr_pkg::HEX_TERM_W-1:0];
      beat.dec_term = wide_ch - {1'b0, tpr_pkg::CH_ZERO};
   end

endmodule

@@ sv/tpr_queue.sv @@
// short beat queue between the front end and the record builder
`include "assert_macros.svh"

module tpr_queue #(
   parameter int DEPTH = tpr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  tpr_pkg::beat_type in_beat,
   output logic              out_valid,
   input  logic              out_pop,
   output tpr_pkg::beat_type out_beat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tpr_pkg::beat_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign in_stall  = reset || (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_beat  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_beat;
      end
   end

   `TPR_ASSERT_NEXT(a_fill_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue fill lost a beat")
   `TPR_ASSERT_NEXT(a_drain_down, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue drain miscounted")

endmodule

@@ sv/tpr_back.sv @@
// back end: builds records from decoded beats and holds the result register
`include "assert_macros.svh"

module tpr_back #(
   parameter int ADDR_WIDTH = tpr_pkg::ADDR_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               beat_valid,
   output logic                               beat_pop,
   input  tpr_pkg::beat_type                  beat,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tpr_pkg::DATA_W-1:0]         rsp_pc,
   output logic [tpr_pkg::DATA_W-1:0]         rsp_addr,
   output logic [tpr_pkg::CHAR_W-1:0]         rsp_op,
   output logic signed [tpr_pkg::SIZE_W-1:0]  rsp_size,
   output logic                               rsp_record_ok
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_PC_WS,
      PH_PC_TOK,
      PH_AD_WS,
      PH_AD_TOK,
      PH_OP_WS,
      PH_SZ_WS,
      PH_SZ_TOK,
      PH_SKIP
   } phase_type;

   phase_type                         phase_ff, phase_in, cur_phase;
   logic [ADDR_WIDTH-1:0]             pc_acc_ff, pc_acc_in;
   logic [ADDR_WIDTH-1:0]             addr_acc_ff, addr_acc_in;
   logic [tpr_pkg::CHAR_W-1:0]        op_reg_ff, op_reg_in;
   logic [tpr_pkg::SIZE_W-1:0]        size_acc_ff, size_acc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tpr_pkg::DATA_W-1:0]        rsp_pc_ff, rsp_addr_ff;
   logic [tpr_pkg::CHAR_W-1:0]        rsp_op_ff;
   logic [tpr_pkg::SIZE_W-1:0]        rsp_size_ff;
   logic                              rsp_record_ok_ff;
   logic                              out_free;
   logic                              emit;
   logic [ADDR_WIDTH-1:0]             hex_ext;
   logic [ADDR_WIDTH-1:0]             pc_fold;
   logic [ADDR_WIDTH-1:0]             addr_fold;
   logic [tpr_pkg::SIZE_W-1:0]        size_fold;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign beat_pop = beat_valid && out_free;

   always_comb begin
      hex_ext   = {{(ADDR_WIDTH - tpr_pkg::HEX_TERM_W){beat.hex_term[tpr_pkg::HEX_TERM_W-1]}},
                   beat.hex_term};
      pc_fold   = {pc_acc_ff[ADDR_WIDTH-5:0], 4'h0} | hex_ext;
      addr_fold = {addr_acc_ff[ADDR_WIDTH-5:0], 4'h0} | hex_ext;
      size_fold = {size_acc_ff[tpr_pkg::SIZE_W-4:0], 3'b000}
                + {size_acc_ff[tpr_pkg::SIZE_W-2:0], 1'b0}
                + {{(tpr_pkg::SIZE_W - tpr_pkg::DEC_TERM_W){beat.dec_term[tpr_pkg::DEC_TERM_W-1]}},
                   beat.dec_term};

      cur_phase   = (phase_ff == PH_IDLE) ? PH_PC_WS : phase_ff;
      phase_in    = phase_ff;
      pc_acc_in   = pc_acc_ff;
      addr_acc_in = addr_acc_ff;
      op_reg_in   = op_reg_ff;
      size_acc_in = size_acc_ff;
      emit        = 1'b0;

      if (beat_pop) begin
         if (beat.at_end) begin
            emit     = (phase_ff != PH_IDLE);
            phase_in = PH_IDLE;
         end else begin
            phase_in = cur_phase;
            unique case (cur_phase)
               PH_PC_WS: begin
                  if (!beat.is_ws) begin
                     pc_acc_in = pc_fold;
                     phase_in  = PH_PC_TOK;
                  end
               end
               PH_PC_TOK: begin
                  if (beat.is_ws) begin
                     phase_in = PH_AD_WS;
                  end else begin
                     pc_acc_in = pc_fold;
                  end
               end
               PH_AD_WS: begin
                  if (!beat.is_ws) begin
                     addr_acc_in = addr_fold;
                     phase_in    = PH_AD_TOK;
                  end
               end
               PH_AD_TOK: begin
                  if (beat.is_ws) begin
                     phase_in = PH_OP_WS;
                  end else begin
                     addr_acc_in = addr_fold;
                  end
               end
               PH_OP_WS: begin
                  if (!beat.is_ws) begin
                     op_reg_in = beat.ch;
                     phase_in  = PH_SZ_WS;
                  end
               end
               PH_SZ_WS: begin
                  if (!beat.is_ws) begin
                     size_acc_in = size_fold;
                     phase_in    = PH_SZ_TOK;
                  end
               end
               PH_SZ_TOK: begin
                  if (beat.is_nl) begin
                     emit = 1'b1;
                  end else if (beat.is_ws) begin
                     phase_in = PH_SKIP;
                  end else begin
                     size_acc_in = size_fold;
                  end
               end
               PH_SKIP: begin
                  if (beat.is_nl) begin
                     emit = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_PC_WS;
               end
            endcase
         end
      end

      // end of record or end of trace starts over
      if (beat_pop && (emit || beat.at_end)) begin
         phase_in    = PH_IDLE;
         pc_acc_in   = '0;
         addr_acc_in = '0;
         op_reg_in   = '0;
         size_acc_in = '0;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pc_acc_ff    <= '0;
         addr_acc_ff  <= '0;
         op_reg_ff    <= '0;
         size_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pc_acc_ff    <= pc_acc_in;
         addr_acc_ff  <= addr_acc_in;
         op_reg_ff    <= op_reg_in;
         size_acc_ff  <= size_acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            rsp_pc_ff        <= tpr_pkg::DATA_W'(pc_acc_ff);
            rsp_addr_ff      <= tpr_pkg::DATA_W'(addr_acc_ff);
            rsp_op_ff        <= op_reg_ff;
            rsp_size_ff      <= size_acc_ff;
            rsp_record_ok_ff <= (op_reg_ff != '0) || (size_acc_ff != '0);
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pc        = rsp_pc_ff;
   assign rsp_addr      = rsp_addr_ff;
   assign rsp_op        = rsp_op_ff;
   assign rsp_size      = rsp_size_ff;
   assign rsp_record_ok = rsp_record_ok_ff;

   `TPR_ASSERT_NEXT(a_end_clears, beat_pop && beat.at_end, phase_ff == PH_IDLE && pc_acc_ff == '0 && size_acc_ff == '0, "end of trace left parser state behind")
   `TPR_ASSERT_SAME(a_ok_flag, rsp_valid_ff, rsp_record_ok_ff == (rsp_op_ff != '0 || rsp_size_ff != '0), "record ok flag disagrees with op and size")
   `TPR_ASSERT_SAME(a_hold_pop, rsp_valid_ff && rsp_stall, !beat_pop, "beat taken while result register is blocked")

endmodule

@@ sv/trace_record_parser_top.sv @@
// trace record parser top level: text bytes in, parsed trace records out
//
// req channel: one beat per text byte (req_char_in), or an end marker
//   (req_at_end high) that flushes a partial record and restarts the parser.
// rsp channel: one beat per record (pc, addr, op, size, record_ok), sent
//   when the newline after the size token or an end marker is processed.
// a beat moves when valid is high and stall is low at a rising clock edge.
// throughput: one byte per cycle while neither req_stall nor rsp_stall holds;
//   the front end only decodes, the back end updates its state per byte.
// the byte closing a record is first written into the beat queue; the builder
//   then pops it and loads the result register, from which the record leaves.
// a beat queue of QUEUE_DEPTH entries sits between decode and builder;
//   req_stall rises when the queue is full.
// when rsp_stall holds while a record waits, the result register keeps it and the
//   builder stops; the queue keeps taking bytes until it fills.
// reset (synchronous) empties the queue, drops any pending result and
//   returns the parser to idle; req_stall is high during reset.
module trace_record_parser_top #(
   parameter int ADDR_WIDTH  = tpr_pkg::ADDR_WIDTH_DEF,
   parameter int QUEUE_DEPTH = tpr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tpr_pkg::CHAR_W-1:0]        req_char_in,
   input  logic                              req_at_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tpr_pkg::DATA_W-1:0]        rsp_pc,
   output logic [tpr_pkg::DATA_W-1:0]        rsp_addr,
   output logic [tpr_pkg::CHAR_W-1:0]        rsp_op,
   output logic signed [tpr_pkg::SIZE_W-1:0] rsp_size,
   output logic                              rsp_record_ok
);

   tpr_pkg::beat_type dec_beat;
   tpr_pkg::beat_type q_beat;
   logic              q_valid;
   logic              q_pop;

   tpr_front u_front (
      .char_in (req_char_in),
      .at_end  (req_at_end),
      .beat    (dec_beat)
   );

   tpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_beat   (dec_beat),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_beat  (q_beat)
   );

   tpr_back #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .beat_valid    (q_valid),
      .beat_pop      (q_pop),
      .beat          (q_beat),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pc        (rsp_pc),
      .rsp_addr      (rsp_addr),
      .rsp_op        (rsp_op),
      .rsp_size      (rsp_size),
      .rsp_record_ok (rsp_record_ok)
   );

endmodule

@@ bench/tb.sv @@
// testbench for trace_record_parser_top: directed and random trace text against a parser model
`timescale 1ns / 1ps

module tb;

   localparam int          ADDR_BITS   = 64;
   localparam logic [63:0] ADDR_MASK   = {64{1'b1}} >> (64 - ADDR_BITS);
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          DRAIN_WAIT  = 8;
   localparam logic [6:0]  CH_VTAB     = 7'h0B;
   localparam logic [6:0]  CH_FORMFEED = 7'h0C;
   localparam logic [6:0]  CH_NUL      = 7'h00;
   localparam logic [6:0]  CH_DEL      = 7'h7F;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PC_GAP, ST_PC_DIGITS, ST_ADDR_GAP, ST_ADDR_DIGITS,
      ST_OP_GAP, ST_SIZE_GAP, ST_SIZE_DIGITS, ST_SKIP_LINE
   } parse_state_type;

   typedef struct {
      logic [63:0]        pc;
      logic [63:0]        addr;
      logic [6:0]         op;
      logic signed [31:0] size;
      logic               ok;
   } trace_record_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [6:0]         req_char_in = '0;
   logic               req_at_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [63:0]        rsp_pc;
   logic [63:0]        rsp_addr;
   logic [6:0]         rsp_op;
   logic signed [31:0] rsp_size;
   logic               rsp_record_ok;

   // parser model state
   parse_state_type prs_state = ST_IDLE;
   logic [63:0]     prs_pc = '0;
   logic [63:0]     prs_addr = '0;
   logic [6:0]      prs_op = '0;
   logic [31:0]     prs_size = '0;

   trace_record_type expected_records[$];
   trace_record_type head_rec;
   logic [6:0]       line_q[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int error_count = 0;
   int beats_sent = 0;
   int end_markers = 0;
   int records_checked = 0;
   int cycle_count = 0;

   string hex_digits = "0123456789abcdefABCDEF";
   string op_chars = "RWIM";

   trace_record_parser_top #(.ADDR_WIDTH(ADDR_BITS)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_in   (req_char_in),
      .req_at_end    (req_at_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pc        (rsp_pc),
      .rsp_addr      (rsp_addr),
      .rsp_op        (rsp_op),
      .rsp_size      (rsp_size),
      .rsp_record_ok (rsp_record_ok)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic bit is_space(logic [6:0] c);
      return c == tpr_pkg::CH_SPACE || (c >= tpr_pkg::CH_TAB && c <= tpr_pkg::CH_CR);
   endfunction

   function automatic logic [63:0] fold_hex(logic [63:0] acc, logic [6:0] c);
      longint term;
      if (c <= tpr_pkg::CH_NINE) term = longint'(c) - longint'(tpr_pkg::CH_ZERO);
      else term = longint'(c & tpr_pkg::CASE_MASK) - longint'(tpr_pkg::HEX_ALPHA_BASE);
      return ((acc << 4) | 64'(term)) & ADDR_MASK;
   endfunction

   function automatic logic [31:0] fold_dec(logic [31:0] acc, logic [6:0] c);
      return acc * 32'd10 + 32'(c) - 32'(tpr_pkg::CH_ZERO);
   endfunction

   function automatic void push_record();
      trace_record_type rec;
      rec.pc   = prs_pc & ADDR_MASK;
      rec.addr = prs_addr & ADDR_MASK;
      rec.op   = prs_op;
      rec.size = prs_size;
      rec.ok   = (prs_op != '0) || (prs_size != '0);
      expected_records.push_back(rec);
      prs_state = ST_IDLE;
      prs_pc = '0;
      prs_addr = '0;
      prs_op = '0;
      prs_size = '0;
   endfunction

   // advance the parser model by one accepted beat
   function automatic void parse_beat(logic [6:0] c, logic at_end);
      bit ws;
      ws = is_space(c);
      if (at_end) begin
         if (prs_state != ST_IDLE) push_record();
         return;
      end
      if (prs_state == ST_IDLE) prs_state = ST_PC_GAP;
      case (prs_state)
         ST_PC_GAP: if (!ws) begin
            prs_pc = fold_hex(prs_pc, c);
            prs_state = ST_PC_DIGITS;
         end
         ST_PC_DIGITS: if (ws) prs_state = ST_ADDR_GAP;
            else prs_pc = fold_hex(prs_pc, c);
         ST_ADDR_GAP: if (!ws) begin
            prs_addr = fold_hex(prs_addr, c);
            prs_state = ST_ADDR_DIGITS;
         end
         ST_ADDR_DIGITS: if (ws) prs_state = ST_OP_GAP;
            else prs_addr = fold_hex(prs_addr, c);
         ST_OP_GAP: if (!ws) begin
            prs_op = c;
            prs_state = ST_SIZE_GAP;
         end
         ST_SIZE_GAP: if (!ws) begin
            prs_size = fold_dec(prs_size, c);
            prs_state = ST_SIZE_DIGITS;
         end
         ST_SIZE_DIGITS: begin
            if (c == tpr_pkg::CH_NEWLINE) push_record();
            else if (ws) prs_state = ST_SKIP_LINE;
            else prs_size = fold_dec(prs_size, c);
         end
         default: if (c == tpr_pkg::CH_NEWLINE) push_record();
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < 40)
         $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic send_beat(input logic [6:0] c, input logic at_end);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_at_end <= at_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_beat(c, at_end);
      beats_sent++;
      if (at_end) end_markers++;
   endtask

   task automatic wait_records_drained();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // result side: check each record, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            report_mismatch("unexpected record pc", rsp_pc, '0);
         end else begin
            head_rec = expected_records.pop_front();
            if (rsp_pc !== head_rec.pc) report_mismatch("pc", rsp_pc, head_rec.pc);
            if (rsp_addr !== head_rec.addr) report_mismatch("addr", rsp_addr, head_rec.addr);
            if (rsp_op !== head_rec.op) report_mismatch("op", rsp_op, head_rec.op);
            if (rsp_size !== head_rec.size)
               report_mismatch("size", rsp_size, head_rec.size);
            if (rsp_record_ok !== head_rec.ok)
               report_mismatch("record_ok", rsp_record_ok, head_rec.ok);
            records_checked++;
         end
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < rx_idle_pct);
   end

   function automatic logic [6:0] rand_non_space();
      logic [6:0] c;
      do c = 7'($urandom_range(0, 127)); while (is_space(c));
      return c;
   endfunction

   function automatic void add_space(int n, bit allow_nl);
      logic [6:0] pick[5] = '{tpr_pkg::CH_TAB, CH_VTAB, CH_FORMFEED, tpr_pkg::CH_CR,
                              tpr_pkg::CH_SPACE};
      repeat (n) begin
         if (allow_nl && $urandom_range(0, 99) < 15) line_q.push_back(tpr_pkg::CH_NEWLINE);
         else line_q.push_back($urandom_range(0, 3) == 0 ? pick[$urandom_range(0, 4)]
                                                          : tpr_pkg::CH_SPACE);
      end
   endfunction

   function automatic void add_token(int n, bit decimal);
      repeat (n) begin
         if ($urandom_range(0, 99) < 5) line_q.push_back(rand_non_space());
         else if (decimal) line_q.push_back(tpr_pkg::CH_ZERO + 7'($urandom_range(0, 9)));
         else line_q.push_back(7'(hex_digits[$urandom_range(0, hex_digits.len() - 1)]));
      end
   endfunction

   task automatic test_end_while_idle();
      send_beat(CH_DEL, 1'b1);
   endtask

   // negative hex term, newline before op, null op
   task automatic test_bad_digit_null_op();
      send_beat(7'h21, 1'b0);
      send_beat(CH_VTAB, 1'b0);
      send_beat(7'("F"), 1'b0);
      send_beat(tpr_pkg::CH_NEWLINE, 1'b0);
      send_beat(CH_NUL, 1'b0);
      send_beat(tpr_pkg::CH_SPACE, 1'b0);
      send_beat(tpr_pkg::CH_NINE, 1'b0);
      send_beat(tpr_pkg::CH_NEWLINE, 1'b0);
   endtask

   // top byte as a digit, newline after op, junk after size
   task automatic test_extreme_bytes();
      send_beat(CH_DEL, 1'b0);
      send_beat(tpr_pkg::CH_SPACE, 1'b0);
      send_beat(tpr_pkg::CH_ZERO, 1'b0);
      send_beat(tpr_pkg::CH_CR, 1'b0);
      send_beat(7'("R"), 1'b0);
      send_beat(tpr_pkg::CH_NEWLINE, 1'b0);
      send_beat(tpr_pkg::CH_NINE, 1'b0);
      send_beat(tpr_pkg::CH_NINE, 1'b0);
      send_beat(7'("x"), 1'b0);
      send_beat(tpr_pkg::CH_SPACE, 1'b0);
      send_beat(7'("z"), 1'b0);
      send_beat(tpr_pkg::CH_NEWLINE, 1'b0);
   endtask

   // whitespace-only record and a record cut inside the pc token
   task automatic test_partial_records();
      send_beat(tpr_pkg::CH_SPACE, 1'b0);
      send_beat(CH_NUL, 1'b1);
      send_beat(7'("a"), 1'b0);
      send_beat(CH_DEL, 1'b1);
   endtask

   task automatic test_random_traces(input int n_beats, input int tx_pct, input int rx_pct);
      int start;
      int kind;
      int cut;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start = beats_sent;
      while (beats_sent - start < n_beats) begin
         line_q.delete();
         kind = $urandom_range(0, 99);
         cut = -1;
         if (kind < 6) begin
            repeat ($urandom_range(1, 8))
               line_q.push_back(7'($urandom_range(0, 127)));
            if ($urandom_range(0, 1)) cut = line_q.size();
         end else if (kind < 9) begin
            add_space($urandom_range(1, 3), 1'b1);
            cut = line_q.size();
         end else begin
            add_space($urandom_range(0, 2), 1'b1);
            add_token($urandom_range(0, 9) == 0 ? $urandom_range(15, 20)
                                                : $urandom_range(1, 8), 1'b0);
            add_space($urandom_range(1, 2), 1'b1);
            add_token($urandom_range(0, 9) == 0 ? $urandom_range(15, 20)
                                                : $urandom_range(1, 8), 1'b0);
            add_space($urandom_range(1, 2), 1'b1);
            case ($urandom_range(0, 9))
               0: line_q.push_back(CH_NUL);
               1: line_q.push_back(rand_non_space());
               default: line_q.push_back(7'(op_chars[$urandom_range(0, 3)]));
            endcase
            add_space($urandom_range(1, 2), 1'b1);
            add_token($urandom_range(0, 9) == 0 ? $urandom_range(9, 12)
                                                : $urandom_range(1, 4), 1'b1);
            if ($urandom_range(0, 99) < 30) begin
               add_space(1, 1'b0);
               repeat ($urandom_range(0, 3)) begin
                  line_q.push_back(7'($urandom_range(0, 127)));
                  if (line_q[$] == tpr_pkg::CH_NEWLINE) line_q[$] = CH_DEL;
               end
            end
            line_q.push_back(tpr_pkg::CH_NEWLINE);
            if ($urandom_range(0, 99) < 8) cut = $urandom_range(0, line_q.size() - 1);
         end
         for (int i = 0; i < (cut < 0 ? line_q.size() : cut); i++)
            send_beat(line_q[i], 1'b0);
         if (cut >= 0 || $urandom_range(0, 99) < 5)
            send_beat(7'($urandom_range(0, 127)), 1'b1);
      end
   endtask

   task automatic test_drain_pause();
      wait_records_drained();
      test_random_traces(40, 8, 81);
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d records outstanding",
               cycle_count, expected_records.size());
      $display("** trace_record_parser_top: FAILED **");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle_pct = 8;
      rx_idle_pct = 81;
      test_end_while_idle();
      test_bad_digit_null_op();
      test_extreme_bytes();
      test_partial_records();
      test_random_traces(260, 8, 81);
      test_drain_pause();
      test_random_traces(260, 81, 8);
      test_random_traces(260, 0, 0);
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_records.size() != 0)
         report_mismatch("records left over", expected_records.size(), '0);
      $display("sent %0d text beats including %0d end markers, checked %0d records",
               beats_sent, end_markers, records_checked);
      $display("idle mixes: sender light/receiver heavy, reversed, none; %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("** trace_record_parser_top: PASSED **");
      end else begin
         $display("** trace_record_parser_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tpr_pkg.sv
sv/tpr_front.sv
sv/tpr_queue.sv
sv/tpr_back.sv
sv/trace_record_parser_top.sv
bench/tb.sv
